[rtl/hvp_pkg.sv]
`default_nettype none

package hvp_pkg;

   // register indexes on the csr port
   typedef enum logic [2:0] {
      CSR_HEIGHT_MODE      = 3'd0,
      CSR_VERTICAL_SCALE   = 3'd1,
      CSR_COS_YAW          = 3'd2,
      CSR_SIN_YAW          = 3'd3,
      CSR_PITCH_COS        = 3'd4,
      CSR_PITCH_SIN        = 3'd5,
      CSR_VIEW_SCALE       = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      HM_RED   = 2'd0,
      HM_GREEN = 2'd1,
      HM_BLUE  = 2'd2,
      HM_LUMA  = 2'd3
   } height_mode_type;

   typedef struct packed {
      height_mode_type     height_mode;
      logic [14:0]         vertical_scale;
      logic signed [15:0]  cos_yaw;
      logic signed [15:0]  sin_yaw;
      logic signed [15:0]  pitch_cos;
      logic signed [15:0]  pitch_sin;
      logic [15:0]         view_scale;
   } cfg_type;

   localparam int unsigned NUM_W   = 48;   // rounded dividend 32|n| + d
   localparam int unsigned DEN_W   = 25;   // divisor 2d
   localparam int unsigned QUO_W   = 32;   // quotient bits resolved
   localparam int unsigned DEPTH_W = 24;

   // luminance weights, Q0.16
   localparam logic [31:0] LUMA_R = 32'd19595;
   localparam logic [31:0] LUMA_G = 32'd38470;
   localparam logic [31:0] LUMA_B = 32'd7471;

   // ceil(2^32 / 255): exact floor(v/255) for v < 2^24
   localparam logic [24:0] RECIP_255 = 25'd16843010;

   localparam logic signed [30:0] DEPTH_BASE = 31'sd327680;
   localparam logic signed [30:0] DEPTH_MIN  = 31'sd78643;
   localparam logic signed [30:0] DEPTH_MAX  = 31'sd16777215;

   // operands handed from the transform pipe to the divider
   typedef struct packed {
      logic [NUM_W-1:0]   num_x;
      logic [NUM_W-1:0]   num_y;
      logic               neg_x;
      logic               neg_y;
      logic [DEN_W-1:0]   den;
      logic [DEPTH_W-1:0] depth;
   } div_req_type;

   typedef struct packed {
      logic signed [31:0] screen_x;
      logic signed [31:0] screen_y;
      logic [DEPTH_W-1:0] depth;
   } div_rsp_type;

endpackage

`default_nettype wire

[rtl/heightfield_vertex_projection_unit.sv]
`default_nettype none

// Channel   Dir  Ports                      Word
// req       in   req_tvalid/tready/tdata    72 bits, one vertex
// rsp       out  rsp_tvalid/tready/tdata    88 bits, one projected vertex
// csr       in   csr_we/index/wdata         16-bit register write
//
// The pipe has 7 transform stages and 34 divider stages
// (one quotient bit per step stage, x and y lanes side by side).
// One word enters per cycle while rsp is not stalled; the whole pipe advances together.
// A stall on rsp freezes every stage; req_tready drops only while rsp
// holds a word that is not taken.
// Synchronous active-high reset clears valid bits and loads config registers with defaults.
module heightfield_vertex_projection_unit
   import hvp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [23:0] world_x, [47:24] world_z, [55:48] red_level,
   // [63:56] green_level, [71:64] blue_level
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] screen_x, [63:32] screen_y, [87:64] depth
   output logic [87:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type     cfg_ff;
   logic        en;
   logic        xf_valid;
   div_req_type xf_req;
   div_rsp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.height_mode      <= HM_LUMA;
         cfg_ff.vertical_scale   <= 15'd4096;
         cfg_ff.cos_yaw          <= 16'sd13421;
         cfg_ff.sin_yaw          <= -16'sd9397;
         cfg_ff.pitch_cos        <= 16'sd10087;
         cfg_ff.pitch_sin        <= 16'sd12911;
         cfg_ff.view_scale       <= 16'd11878;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEIGHT_MODE:      cfg_ff.height_mode <= height_mode_type'(csr_wdata[1:0]);
            CSR_VERTICAL_SCALE:   cfg_ff.vertical_scale   <= csr_wdata[14:0];
            CSR_COS_YAW:          cfg_ff.cos_yaw          <= csr_wdata;
            CSR_SIN_YAW:          cfg_ff.sin_yaw          <= csr_wdata;
            CSR_PITCH_COS:        cfg_ff.pitch_cos        <= csr_wdata;
            CSR_PITCH_SIN:        cfg_ff.pitch_sin        <= csr_wdata;
            CSR_VIEW_SCALE:       cfg_ff.view_scale       <= csr_wdata;
            default: ;  // unused index, write dropped
         endcase
      end
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   hvp_xform u_xform (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req_tvalid),
      .world_x     (req_tdata[23:0]),
      .world_z     (req_tdata[47:24]),
      .red_level   (req_tdata[55:48]),
      .green_level (req_tdata[63:56]),
      .blue_level  (req_tdata[71:64]),
      .cfg         (cfg_ff),
      .out_valid   (xf_valid),
      .out_req     (xf_req)
   );

   hvp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (xf_valid),
      .in_req    (xf_req),
      .out_valid (rsp_tvalid),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = {rsp.depth, rsp.screen_y, rsp.screen_x};

`ifndef SYNTHESIS
   a_depth_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[87:64] >= DEPTH_MIN[23:0]))
      else $error("depth below floor");

   a_ready_rule: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready not tied to output stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("valid word after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(cfg_ff) || $past(csr_we))
      else $error("config changed without write");
`endif

endmodule

`default_nettype wire

[rtl/hvp_xform.sv]
`default_nettype none

module hvp_xform
   import hvp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire logic               in_valid,
   input  wire logic signed [23:0] world_x,
   input  wire logic signed [23:0] world_z,
   input  wire logic [7:0]         red_level,
   input  wire logic [7:0]         green_level,
   input  wire logic [7:0]         blue_level,
   input  wire cfg_type            cfg,
   output logic                    out_valid,
   output div_req_type             out_req
);

   logic [7:1] vld_ff;

   // stage 1: height weighting, yaw products
   logic [23:0]        w_in, w1_ff;
   logic [31:0]        luma;
   logic signed [39:0] pcx_in, psz_in, psx_in, pcz_in;
   logic signed [39:0] pcx1_ff, psz1_ff, psx1_ff, pcz1_ff;

   assign luma = 32'(red_level) * LUMA_R + 32'(green_level) * LUMA_G
               + 32'(blue_level) * LUMA_B;

   always_comb begin
      unique case (cfg.height_mode)
         HM_RED:   w_in = {red_level, 16'h0000};
         HM_GREEN: w_in = {green_level, 16'h0000};
         HM_BLUE:  w_in = {blue_level, 16'h0000};
         HM_LUMA:  w_in = luma[23:0];
         default:  w_in = luma[23:0];
      endcase
   end

   assign pcx_in = cfg.cos_yaw * world_x;
   assign psz_in = cfg.sin_yaw * world_z;
   assign psx_in = cfg.sin_yaw * world_x;
   assign pcz_in = cfg.cos_yaw * world_z;

   // stage 2: divide by 255, yaw rounding
   logic [24:0]        hnum;
   logic [49:0]        hprod;
   logic [16:0]        h2_ff;
   logic signed [40:0] xsum, zsum;
   logic signed [26:0] xyaw2_ff, zyaw2_ff;

   assign hnum  = {1'b0, w1_ff} + 25'd127;
   assign hprod = 50'(hnum) * 50'(RECIP_255);
   assign xsum  = 41'(pcx1_ff) - 41'(psz1_ff) + 41'sd8192;
   assign zsum  = 41'(psx1_ff) + 41'(pcz1_ff) + 41'sd8192;

   // stage 3: vertical scale
   logic [31:0]        hs;
   logic [32:0]        hr;
   logic [19:0]        y3_ff;
   logic signed [26:0] xyaw3_ff, zyaw3_ff;

   assign hs = 32'(h2_ff) * 32'(cfg.vertical_scale);
   assign hr = {1'b0, hs} + 33'd2048;

   // stage 4: pitch products
   logic signed [20:0] ys;
   logic signed [42:0] pcy_in, psw_in, psy_in, pcw_in;
   logic signed [42:0] pcy4_ff, psw4_ff, psy4_ff, pcw4_ff;
   logic signed [26:0] xyaw4_ff;

   assign ys     = {1'b0, y3_ff};
   assign pcy_in = cfg.pitch_cos * ys;
   assign psw_in = cfg.pitch_sin * zyaw3_ff;
   assign psy_in = cfg.pitch_sin * ys;
   assign pcw_in = cfg.pitch_cos * zyaw3_ff;

   // stage 5: pitch rounding
   logic signed [43:0] ysum, wsum;
   logic signed [29:0] ypitch5_ff, zpitch5_ff;
   logic signed [26:0] xyaw5_ff;

   assign ysum = 44'(pcy4_ff) - 44'(psw4_ff) + 44'sd8192;
   assign wsum = 44'(psy4_ff) + 44'(pcw4_ff) + 44'sd8192;

   // stage 6: depth clamp, projection scale products
   logic signed [30:0]  dsum;
   logic [23:0]         depth_in, depth6_ff;
   logic signed [16:0]  ps_s;
   logic signed [43:0]  px_in, px6_ff;
   logic signed [46:0]  py_in, py6_ff;

   assign dsum = 31'(zpitch5_ff) + DEPTH_BASE;
   assign ps_s = {1'b0, cfg.view_scale};
   assign px_in = xyaw5_ff * ps_s;
   assign py_in = ypitch5_ff * ps_s;

   always_comb begin
      priority if (dsum < DEPTH_MIN) depth_in = DEPTH_MIN[23:0];
      else if (dsum > DEPTH_MAX)     depth_in = DEPTH_MAX[23:0];
      else                           depth_in = dsum[23:0];
   end

   // stage 7: sign/magnitude, rounded dividend
   logic [43:0] mx;
   logic [46:0] my;

   assign mx = px6_ff[43] ? 44'(-px6_ff) : 44'(px6_ff);
   assign my = py6_ff[46] ? 47'(-py6_ff) : 47'(py6_ff);

   div_req_type req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[6:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w1_ff      <= w_in;
         pcx1_ff    <= pcx_in;
         psz1_ff    <= psz_in;
         psx1_ff    <= psx_in;
         pcz1_ff    <= pcz_in;
         h2_ff      <= hprod[48:32];
         xyaw2_ff   <= xsum[40:14];
         zyaw2_ff   <= zsum[40:14];
         y3_ff      <= hr[31:12];
         xyaw3_ff   <= xyaw2_ff;
         zyaw3_ff   <= zyaw2_ff;
         pcy4_ff    <= pcy_in;
         psw4_ff    <= psw_in;
         psy4_ff    <= psy_in;
         pcw4_ff    <= pcw_in;
         xyaw4_ff   <= xyaw3_ff;
         ypitch5_ff <= ysum[43:14];
         zpitch5_ff <= wsum[43:14];
         xyaw5_ff   <= xyaw4_ff;
         depth6_ff  <= depth_in;
         px6_ff     <= px_in;
         py6_ff     <= py_in;
         req_ff.num_x <= {mx[42:0], 5'b00000} + 48'(depth6_ff);
         req_ff.num_y <= {my[42:0], 5'b00000} + 48'(depth6_ff);
         req_ff.neg_x <= px6_ff[43];
         req_ff.neg_y <= py6_ff[46];
         req_ff.den   <= {depth6_ff, 1'b0};
         req_ff.depth <= depth6_ff;
      end
   end

   assign out_valid = vld_ff[7];
   assign out_req   = req_ff;

endmodule

`default_nettype wire

[rtl/hvp_div.sv]
`default_nettype none

module hvp_div
   import hvp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire div_req_type in_req,
   output logic             out_valid,
   output div_rsp_type      out_rsp
);

   // one quotient bit per stage for both lanes; remainder always < den
   logic [DEN_W-1:0]   rx_ff [0:QUO_W];
   logic [DEN_W-1:0]   ry_ff [0:QUO_W];
   logic [NUM_W-1:0]   nx_ff [0:QUO_W];
   logic [NUM_W-1:0]   ny_ff [0:QUO_W];
   logic [QUO_W-1:0]   qx_ff [0:QUO_W];
   logic [QUO_W-1:0]   qy_ff [0:QUO_W];
   logic [DEN_W-1:0]   den_ff [0:QUO_W];
   logic [DEPTH_W-1:0] dep_ff [0:QUO_W];
   logic               negx_ff [0:QUO_W];
   logic               negy_ff [0:QUO_W];
   logic [QUO_W:0]     vld_ff;
   logic               out_vld_ff;
   div_rsp_type        rsp_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff[0]  <= DEN_W'(in_req.num_x[NUM_W-1:QUO_W]);
         ry_ff[0]  <= DEN_W'(in_req.num_y[NUM_W-1:QUO_W]);
         nx_ff[0]  <= in_req.num_x;
         ny_ff[0]  <= in_req.num_y;
         qx_ff[0]  <= '0;
         qy_ff[0]  <= '0;
         den_ff[0] <= in_req.den;
         dep_ff[0] <= in_req.depth;
         negx_ff[0] <= in_req.neg_x;
         negy_ff[0] <= in_req.neg_y;
      end
   end

   for (genvar s = 1; s <= QUO_W; s++) begin : g_step
      localparam int unsigned B = QUO_W - s;
      logic [DEN_W:0] tx, ty;
      logic           gex, gey;

      assign tx  = {rx_ff[s-1], nx_ff[s-1][B]};
      assign ty  = {ry_ff[s-1], ny_ff[s-1][B]};
      assign gex = tx >= {1'b0, den_ff[s-1]};
      assign gey = ty >= {1'b0, den_ff[s-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            rx_ff[s]   <= gex ? DEN_W'(tx - {1'b0, den_ff[s-1]}) : tx[DEN_W-1:0];
            ry_ff[s]   <= gey ? DEN_W'(ty - {1'b0, den_ff[s-1]}) : ty[DEN_W-1:0];
            nx_ff[s]   <= nx_ff[s-1];
            ny_ff[s]   <= ny_ff[s-1];
            qx_ff[s]   <= {qx_ff[s-1][QUO_W-2:0], gex};
            qy_ff[s]   <= {qy_ff[s-1][QUO_W-2:0], gey};
            den_ff[s]  <= den_ff[s-1];
            dep_ff[s]  <= dep_ff[s-1];
            negx_ff[s] <= negx_ff[s-1];
            negy_ff[s] <= negy_ff[s-1];
         end
      end
   end

   // |quotient| < 2^31 by operand ranges, so no saturation is reachable
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.screen_x <= negx_ff[QUO_W] ? -qx_ff[QUO_W] : qx_ff[QUO_W];
         // screen y is the negated projection
         rsp_ff.screen_y <= negy_ff[QUO_W] ? qy_ff[QUO_W] : -qy_ff[QUO_W];
         rsp_ff.depth    <= dep_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[QUO_W-1:0], in_valid};
         out_vld_ff <= vld_ff[QUO_W];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
module tb;
   import hvp_pkg::*;

   // one bogus register index: writes to it must not disturb any register
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   // pipe is 41 deep; extra wait after draining before touching registers
   localparam int DRAIN_CYCLES = 50;
   // idle cycles with no word moving on either side before giving up
   localparam int STALL_LIMIT  = 3000;
   localparam int PHASE_ITEMS  = 150;

   // Expected-result store plus a copy of the register file.
   // note_vertex() predicts the projection of each accepted vertex,
   // check_result() pops the oldest prediction and compares fields.
   class vertex_board;
      height_mode_type    mode;
      logic [14:0]        vscale;
      logic signed [15:0] cos_yaw, sin_yaw, pitch_cos, pitch_sin;
      logic [15:0]        proj_scale;
      logic [87:0]        projected_q[$];
      int                 errors;

      function new();
         mode       = HM_LUMA;
         vscale     = 15'd4096;
         cos_yaw    = 16'sd13421;
         sin_yaw    = -16'sd9397;
         pitch_cos  = 16'sd10087;
         pitch_sin  = 16'sd12911;
         proj_scale = 16'd11878;
         errors     = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            CSR_HEIGHT_MODE:      mode = height_mode_type'(val[1:0]);
            CSR_VERTICAL_SCALE:   vscale = val[14:0];
            CSR_COS_YAW:          cos_yaw = val;
            CSR_SIN_YAW:          sin_yaw = val;
            CSR_PITCH_COS:        pitch_cos = val;
            CSR_PITCH_SIN:        pitch_sin = val;
            CSR_VIEW_SCALE:       proj_scale = val;
            default: ;
         endcase
      endfunction

      // floor((v + 2^13) / 2^14)
      function longint round14(longint v);
         return (v + 64'sd8192) >>> 14;
      endfunction

      // coord * scale * 16 / d, halves away from zero, then clipped to 32 bits
      function logic [31:0] project(longint coord, longint d, bit negate);
         longint num, q;
         longint unsigned mag;
         num = coord * longint'(proj_scale) * 16;
         mag = (num < 0) ? -num : num;
         q = longint'((mag * 2 + d) / (d * 2));
         if (num < 0) q = -q;
         if (negate) q = -q;
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         return q[31:0];
      endfunction

      function void note_vertex(logic [71:0] w);
         longint x, z, y, xyaw, zyaw, ypitch, zpitch, d;
         longint unsigned weighted, h;
         x = {{40{w[23]}}, w[23:0]};
         z = {{40{w[47]}}, w[47:24]};
         case (mode)
            HM_RED:   weighted = w[55:48] * 64'd65536;
            HM_GREEN: weighted = w[63:56] * 64'd65536;
            HM_BLUE:  weighted = w[71:64] * 64'd65536;
            default:  weighted = w[55:48] * 64'd19595 + w[63:56] * 64'd38470
                                 + w[71:64] * 64'd7471;
         endcase
         h = (weighted + 127) / 255;
         y = longint'((h * vscale + 2048) >> 12);
         xyaw   = round14(cos_yaw * x - sin_yaw * z);
         zyaw   = round14(sin_yaw * x + cos_yaw * z);
         ypitch = round14(pitch_cos * y - pitch_sin * zyaw);
         zpitch = round14(pitch_sin * y + pitch_cos * zyaw);
         d = 64'sd327680 + zpitch;
         if (d < 64'sd78643) d = 64'sd78643;
         if (d > 64'sd16777215) d = 64'sd16777215;
         projected_q.insert(projected_q.size(), {d[23:0], project(ypitch, d, 1'b1),
                                                 project(xyaw, d, 1'b0)});
      endfunction

      function void check_result(logic [87:0] got);
         logic [87:0] exp_w;
         if (projected_q.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
            return;
         end
         exp_w = projected_q.pop_front();
         if (got[31:0] !== exp_w[31:0]) begin
            $display("%0t: screen_x expected %0d got %0d", $time,
                     $signed(exp_w[31:0]), $signed(got[31:0]));
            errors++;
         end
         if (got[63:32] !== exp_w[63:32]) begin
            $display("%0t: screen_y expected %0d got %0d", $time,
                     $signed(exp_w[63:32]), $signed(got[63:32]));
            errors++;
         end
         if (got[87:64] !== exp_w[87:64]) begin
            $display("%0t: depth expected %0d got %0d", $time,
                     exp_w[87:64], got[87:64]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [23:0] world_x, [47:24] world_z, [55:48] red, [63:56] green, [71:64] blue
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [31:0] screen_x, [63:32] screen_y, [87:64] depth
   logic [87:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   vertex_board board = new();
   int          burst_left = 0;
   int          idle_cycles = 0;
   int          cycle_count = 0;

   always #10 clock = ~clock;

   heightfield_vertex_projection_unit uut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_we, .csr_index, .csr_wdata
   );

   // receiver: checks each taken word, then picks next ready from a
   // pattern that rotates through four modes (free, coin flip, periodic, light)
   always @(posedge clock) begin
      if (rsp_tvalid === 1'b1 && rsp_tready)
         board.check_result(rsp_tdata);
      cycle_count <= cycle_count + 1;
      case ((cycle_count / 256) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= ((cycle_count % 7) >= 3);
         default: rsp_tready <= ($urandom_range(0, 99) < 85);
      endcase
   end

   // watchdog: no word moving on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // one write, then a wait with the enable low
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic apply_config(input logic [1:0] mode, input logic [15:0] vs,
                               input logic [15:0] cy, input logic [15:0] sy,
                               input logic [15:0] cp, input logic [15:0] sp,
                               input logic [15:0] ps);
      write_reg(CSR_HEIGHT_MODE, {14'd0, mode});
      write_reg(CSR_VERTICAL_SCALE, vs);
      write_reg(CSR_COS_YAW, cy);
      write_reg(CSR_SIN_YAW, sy);
      write_reg(CSR_PITCH_COS, cp);
      write_reg(CSR_PITCH_SIN, sp);
      write_reg(CSR_VIEW_SCALE, ps);
   endtask

   // stop sending, wait for every projected vertex to come back,
   // then let the pipe settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.projected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one word on req; bursts of random length separated by random gaps
   task automatic send_vertex(input logic [71:0] w);
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_vertex(w);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(60, 200)
                                                : $urandom_range(1, 30);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   function automatic logic [23:0] random_coord();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
         1, 2, 3: return 24'($urandom);
         default: return 24'($signed($urandom_range(0, 524288)) - 262144);
      endcase
   endfunction

   function automatic logic [71:0] random_vertex();
      logic [23:0] x, z;
      x = random_coord();
      z = random_coord();
      return {8'($urandom), 8'($urandom), 8'($urandom), z, x};
   endfunction

   function automatic logic [15:0] random_trig();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   initial begin
      logic [23:0] xs [3];
      logic [23:0] zs [2];
      xs = '{24'h800000, 24'h7fffff, 24'h000000};
      zs = '{24'h800000, 24'h7fffff};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset registers: coordinate extremes, dark and bright samples
      foreach (xs[i])
         foreach (zs[j]) begin
            send_vertex({8'h00, 8'h00, 8'h00, zs[j], xs[i]});
            send_vertex({8'hff, 8'hff, 8'hff, zs[j], xs[i]});
         end
      drain();
      // single channel heights; bogus index must leave the mode alone
      write_reg(CSR_HEIGHT_MODE, {14'd0, HM_RED});
      write_reg(CSR_UNUSED, 16'hffff);
      send_vertex({8'h00, 8'h00, 8'hff, 24'h010000, 24'h020000});
      drain();
      write_reg(CSR_HEIGHT_MODE, {14'd0, HM_GREEN});
      send_vertex({8'h00, 8'hff, 8'h00, 24'h010000, 24'h020000});
      drain();
      write_reg(CSR_HEIGHT_MODE, {14'd0, HM_BLUE});
      send_vertex({8'hff, 8'h00, 8'h00, 24'h010000, 24'h020000});
      drain();
      // zero vertical scale, and doubled negative pitch cosine so a far
      // vertex saturates depth
      apply_config(HM_LUMA, 16'd0, 16'd16384, 16'd0, 16'h8000, 16'd0, 16'd65535);
      send_vertex({8'hff, 8'hff, 8'hff, 24'h800000, 24'h000000});
      send_vertex({8'hff, 8'hff, 8'hff, 24'h7fffff, 24'h7fffff});
      send_vertex({8'h80, 8'h40, 8'h20, 24'h000000, 24'h800000});

      for (int p = 0; p < 7; p++) begin
         drain();
         case (p)
            0: apply_config(HM_RED, 16'd205, 16'hc000, 16'hc000, 16'hc000, 16'hc000,
                            16'd0);
            1: apply_config(HM_LUMA, 16'd24576, 16'd16384, 16'd16384, 16'd16384,
                            16'd16384, 16'd65535);
            2: apply_config(HM_GREEN, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
                            16'h8000, 16'd65535);
            default: apply_config(2'($urandom), 16'($urandom_range(205, 24576)),
                                  random_trig(), random_trig(), random_trig(),
                                  random_trig(), 16'($urandom));
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_vertex(random_vertex());
      end

      drain();
      if (board.projected_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, board.projected_q.size());
         board.errors++;
      end
      if (board.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

[sim.f]
rtl/hvp_pkg.sv
rtl/hvp_xform.sv
rtl/hvp_div.sv
rtl/heightfield_vertex_projection_unit.sv
tb/sv/tb.sv
